/* src/kbs_pkg.sv */
// kbs_pkg: widths, codes and the control store of the k-nomial broadcast scheduler.
// No dependencies; imported by kbs_divider and knomial_broadcast_scheduler_unit.
package kbs_pkg;

    localparam int MAX_RANKS = 1024;
    localparam int MAX_RADIX = 8;

    localparam int GS_W      = 11;   // group size
    localparam int RANK_W    = 10;   // rank, peer
    localparam int RADIX_W   = 4;
    localparam int POS_W     = 3;    // child position / index, below MAX_RADIX
    localparam int ADDR_W    = 64;
    localparam int LEN_W     = 32;
    localparam int TAG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 11;

    // shared divider: dividend covers rank + 7 * distance + root
    localparam int DIV_W     = 14;
    localparam int DEN_W     = 11;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DONE  = 1'b1;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_RECV = 2'd1;
    localparam logic [1:0] KIND_COPY = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MY_RANK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_RANK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TREE_RADIX = 2'd3;

    // datapath actions, one per step
    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_DIV_ME,
        ACT_DIV_ROOT,
        ACT_VRANK,
        ACT_EMIT_COPY,
        ACT_D_INIT,
        ACT_D_GROW,
        ACT_CLR_POSTED,
        ACT_DIV_VD,
        ACT_DIV_QR,
        ACT_DIV_RECV,
        ACT_EMIT_RECV,
        ACT_I_INIT,
        ACT_DIV_SEND,
        ACT_EMIT_SEND,
        ACT_I_DEC,
        ACT_DIV_DR,
        ACT_EMIT_DONE,
        ACT_PARK
    } t_act;

    // jump conditions, taken when the step completes
    typedef enum logic [3:0] {
        BR_NEXT,
        BR_ALWAYS,
        BR_NOCOPY,
        BR_GS_ONE,
        BR_GROW,
        BR_D_ZERO,
        BR_REM_NZ,
        BR_POS_Z,
        BR_I_ZERO,
        BR_VP_GE,
        BR_POSTED,
        BR_D_NZ
    } t_br;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_act act;
        t_br  br;
        t_pc  tgt;
    } t_uword;

    // step addresses
    localparam t_pc S_IDLE     = 5'd0;
    localparam t_pc S_DIV_ME   = 5'd1;
    localparam t_pc S_DIV_ROOT = 5'd2;
    localparam t_pc S_VRANK    = 5'd3;
    localparam t_pc S_COPY     = 5'd4;
    localparam t_pc S_D_INIT   = 5'd5;
    localparam t_pc S_D_GROW   = 5'd6;
    localparam t_pc S_WALK     = 5'd7;
    localparam t_pc S_DIV_VD   = 5'd8;
    localparam t_pc S_TST_REM  = 5'd9;
    localparam t_pc S_DIV_QR   = 5'd10;
    localparam t_pc S_TST_POS  = 5'd11;
    localparam t_pc S_DIV_RECV = 5'd12;
    localparam t_pc S_RECV     = 5'd13;
    localparam t_pc S_I_INIT   = 5'd14;
    localparam t_pc S_TST_I    = 5'd15;
    localparam t_pc S_TST_VP   = 5'd16;
    localparam t_pc S_DIV_SEND = 5'd17;
    localparam t_pc S_SEND     = 5'd18;
    localparam t_pc S_I_DEC    = 5'd19;
    localparam t_pc S_DIV_DR   = 5'd20;
    localparam t_pc S_TST_POST = 5'd21;
    localparam t_pc S_TST_D    = 5'd22;
    localparam t_pc S_DONE     = 5'd23;
    localparam t_pc S_PARK     = 5'd24;

    // control store
    function automatic t_uword uop_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            S_IDLE:     w = '{act: ACT_ACCEPT,     br: BR_NEXT,   tgt: S_IDLE};
            S_DIV_ME:   w = '{act: ACT_DIV_ME,     br: BR_NEXT,   tgt: S_IDLE};
            S_DIV_ROOT: w = '{act: ACT_DIV_ROOT,   br: BR_NEXT,   tgt: S_IDLE};
            S_VRANK:    w = '{act: ACT_VRANK,      br: BR_NOCOPY, tgt: S_D_INIT};
            S_COPY:     w = '{act: ACT_EMIT_COPY,  br: BR_NEXT,   tgt: S_IDLE};
            S_D_INIT:   w = '{act: ACT_D_INIT,     br: BR_GS_ONE, tgt: S_DONE};
            S_D_GROW:   w = '{act: ACT_D_GROW,     br: BR_GROW,   tgt: S_D_GROW};
            S_WALK:     w = '{act: ACT_CLR_POSTED, br: BR_D_ZERO, tgt: S_DONE};
            S_DIV_VD:   w = '{act: ACT_DIV_VD,     br: BR_NEXT,   tgt: S_IDLE};
            S_TST_REM:  w = '{act: ACT_NONE,       br: BR_REM_NZ, tgt: S_DIV_DR};
            S_DIV_QR:   w = '{act: ACT_DIV_QR,     br: BR_NEXT,   tgt: S_IDLE};
            S_TST_POS:  w = '{act: ACT_NONE,       br: BR_POS_Z,  tgt: S_I_INIT};
            S_DIV_RECV: w = '{act: ACT_DIV_RECV,   br: BR_NEXT,   tgt: S_IDLE};
            S_RECV:     w = '{act: ACT_EMIT_RECV,  br: BR_ALWAYS, tgt: S_DIV_DR};
            S_I_INIT:   w = '{act: ACT_I_INIT,     br: BR_NEXT,   tgt: S_IDLE};
            S_TST_I:    w = '{act: ACT_NONE,       br: BR_I_ZERO, tgt: S_DIV_DR};
            S_TST_VP:   w = '{act: ACT_NONE,       br: BR_VP_GE,  tgt: S_I_DEC};
            S_DIV_SEND: w = '{act: ACT_DIV_SEND,   br: BR_NEXT,   tgt: S_IDLE};
            S_SEND:     w = '{act: ACT_EMIT_SEND,  br: BR_NEXT,   tgt: S_IDLE};
            S_I_DEC:    w = '{act: ACT_I_DEC,      br: BR_ALWAYS, tgt: S_TST_I};
            S_DIV_DR:   w = '{act: ACT_DIV_DR,     br: BR_NEXT,   tgt: S_IDLE};
            S_TST_POST: w = '{act: ACT_NONE,       br: BR_POSTED, tgt: S_PARK};
            S_TST_D:    w = '{act: ACT_NONE,       br: BR_D_NZ,   tgt: S_DIV_VD};
            S_DONE:     w = '{act: ACT_EMIT_DONE,  br: BR_ALWAYS, tgt: S_IDLE};
            S_PARK:     w = '{act: ACT_PARK,       br: BR_ALWAYS, tgt: S_IDLE};
            default:    w = '{act: ACT_NONE,       br: BR_ALWAYS, tgt: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* src/kbs_divider.sv */
// kbs_divider: radix-2 restoring divider, one quotient bit per cycle.
// Depends on kbs_pkg for operand widths.
module kbs_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [kbs_pkg::DIV_W-1:0] i_num,
    input  logic [kbs_pkg::DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [kbs_pkg::DIV_W-1:0] o_quot,
    output logic [kbs_pkg::DEN_W-1:0] o_rem
);
    import kbs_pkg::*;

    logic [DIV_W-1:0]     r_num;   // dividend shifting out, quotient shifting in
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_fits;

    assign w_trial = {r_rem, r_num[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fits  = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[DIV_W-2:0], w_fits};
                r_rem <= w_fits ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

endmodule

/* src/knomial_broadcast_scheduler_unit.sv */
// knomial_broadcast_scheduler_unit: microcoded per-rank k-nomial tree broadcast schedule engine.
// Depends on kbs_pkg (codes, control store) and kbs_divider (shared divide/modulo unit).
// Schedule: each divide or modulo step runs on the shared radix-2 divider. A start reduces rank
// and root modulo the group size, then widens the level distance once per radix power up to
// the top level. At each level a rank with no role moves on; otherwise it finds its position,
// then sends to each child inside the group, skipping indices past the group end, or posts a
// receive. Emit steps wait while the output register is held. One transaction is worked at a
// time; results leave through an output register. Reset (synchronous, active low): sequencer
// idle, no broadcast pending, output empty, registers at group size 1, rank 0, root 0, radix 4.
module knomial_broadcast_scheduler_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [kbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kbs_pkg::CFG_W-1:0]     i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [kbs_pkg::ADDR_W-1:0]    i_buffer_addr,
    input  logic [kbs_pkg::ADDR_W-1:0]    i_source_addr,
    input  logic [kbs_pkg::LEN_W-1:0]     i_byte_length,
    input  logic [kbs_pkg::TAG_W-1:0]     i_msg_tag,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_op_kind,
    output logic [kbs_pkg::RANK_W-1:0]    o_peer_rank,
    output logic [kbs_pkg::ADDR_W-1:0]    o_out_buffer,
    output logic [kbs_pkg::ADDR_W-1:0]    o_out_source,
    output logic [kbs_pkg::LEN_W-1:0]     o_out_length,
    output logic [kbs_pkg::TAG_W-1:0]     o_out_tag,
    output logic                          o_last
);
    import kbs_pkg::*;

    // ---------------- configuration registers ----------------
    logic [GS_W-1:0]    r_cfg_gs;
    logic [RANK_W-1:0]  r_cfg_me;
    logic [RANK_W-1:0]  r_cfg_root;
    logic [RADIX_W-1:0] r_cfg_radix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_gs    <= GS_W'(1);
            r_cfg_me    <= '0;
            r_cfg_root  <= '0;
            r_cfg_radix <= RADIX_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GROUP_SIZE: r_cfg_gs    <= i_cfg_data[GS_W-1:0];
                CFG_MY_RANK:    r_cfg_me    <= i_cfg_data[RANK_W-1:0];
                CFG_ROOT_RANK:  r_cfg_root  <= i_cfg_data[RANK_W-1:0];
                CFG_TREE_RADIX: r_cfg_radix <= i_cfg_data[RADIX_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---------------- sequencer and datapath state ----------------
    t_pc                r_pc;
    logic               r_phase;     // broadcast parked, waiting for completion
    logic               r_div_wait;  // divide in flight for the current step
    logic               r_posted;
    logic [GS_W-1:0]    r_d;         // level distance
    logic [RADIX_W-1:0] r_radix;     // effective radix, latched at start
    logic [RANK_W-1:0]  r_vrank;
    logic [RANK_W-1:0]  r_me;
    logic [RANK_W-1:0]  r_root;
    logic [RANK_W-1:0]  r_q;         // vrank / distance
    logic               r_rem_nz;    // vrank not a multiple of distance
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_i;         // child index, counts down
    logic [RANK_W-1:0]  r_peer;
    logic [ADDR_W-1:0]  r_buf;
    logic [ADDR_W-1:0]  r_src;
    logic [LEN_W-1:0]   r_len;
    logic [TAG_W-1:0]   r_tag;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_out_kind;
    logic [RANK_W-1:0]  r_out_peer;
    logic [ADDR_W-1:0]  r_out_buf;
    logic [ADDR_W-1:0]  r_out_src;
    logic [LEN_W-1:0]   r_out_len;
    logic [TAG_W-1:0]   r_out_tag;
    logic               r_out_last;

    t_uword w_uw;
    assign w_uw = uop_rom(r_pc);

    // ---------------- live group size, radix clamps ----------------
    logic [GS_W-1:0]    w_gs;
    logic [RADIX_W-1:0] w_rclamp;
    logic [RADIX_W-1:0] w_radix_start;
    logic [RADIX_W-1:0] w_rwalk;

    always_comb begin
        if (r_cfg_gs == '0)                    w_gs = GS_W'(1);
        else if (r_cfg_gs > GS_W'(MAX_RANKS))  w_gs = GS_W'(MAX_RANKS);
        else                                   w_gs = r_cfg_gs;

        if (r_cfg_radix < RADIX_W'(2))             w_rclamp = RADIX_W'(2);
        else if (r_cfg_radix > RADIX_W'(MAX_RADIX)) w_rclamp = RADIX_W'(MAX_RADIX);
        else                                       w_rclamp = r_cfg_radix;

        // clamp to the group size as well (small groups only)
        if (GS_W'(w_rclamp) > w_gs) w_radix_start = w_gs[RADIX_W-1:0];
        else                        w_radix_start = w_rclamp;

        w_rwalk = (r_radix < RADIX_W'(2)) ? RADIX_W'(2) : r_radix;
    end

    // ---------------- tree arithmetic ----------------
    logic [DIV_W-1:0]        w_id;        // child index * distance
    logic [DIV_W-1:0]        w_pd;        // position * distance
    logic [DIV_W-1:0]        w_vp;        // child virtual rank
    logic                    w_vp_ge;
    logic [DIV_W-1:0]        w_send_num;
    logic [DIV_W-1:0]        w_recv_num;
    logic [GS_W+RADIX_W-1:0] w_grow_prod;
    logic                    w_grow;
    logic [GS_W:0]           w_vsum;
    logic [GS_W:0]           w_vmod;
    logic                    w_copy;

    assign w_id        = DIV_W'(r_i) * DIV_W'(r_d);
    assign w_pd        = DIV_W'(r_pos) * DIV_W'(r_d);
    assign w_vp        = DIV_W'(r_vrank) + w_id;
    assign w_vp_ge     = w_vp >= DIV_W'(w_gs);
    // peer = (virtual + root) mod size; root folded in before the modulo
    assign w_send_num  = w_vp + DIV_W'(r_cfg_root);
    assign w_recv_num  = DIV_W'(r_vrank) - w_pd + DIV_W'(r_cfg_root);
    assign w_grow_prod = (GS_W+RADIX_W)'(r_d) * (GS_W+RADIX_W)'(r_radix);
    assign w_grow      = w_grow_prod < (GS_W+RADIX_W)'(w_gs);
    assign w_vsum      = (GS_W+1)'(r_me) + (GS_W+1)'(w_gs) - (GS_W+1)'(r_root);
    assign w_vmod      = (w_vsum >= (GS_W+1)'(w_gs)) ? w_vsum - (GS_W+1)'(w_gs) : w_vsum;
    assign w_copy      = (r_me == r_root) && (r_src != r_buf);

    // ---------------- shared divider ----------------
    logic             w_is_div;
    logic             w_div_start;
    logic [DIV_W-1:0] w_div_num;
    logic [DEN_W-1:0] w_div_den;
    logic             w_div_done;
    logic [DIV_W-1:0] w_div_quot;
    logic [DEN_W-1:0] w_div_rem;

    always_comb begin
        w_is_div  = 1'b1;
        w_div_num = '0;
        w_div_den = DEN_W'(w_gs);
        unique case (w_uw.act)
            ACT_DIV_ME:   w_div_num = DIV_W'(r_cfg_me);
            ACT_DIV_ROOT: w_div_num = DIV_W'(r_cfg_root);
            ACT_DIV_VD: begin
                w_div_num = DIV_W'(r_vrank);
                w_div_den = DEN_W'(r_d);
            end
            ACT_DIV_QR: begin
                w_div_num = DIV_W'(r_q);
                w_div_den = DEN_W'(w_rwalk);
            end
            ACT_DIV_RECV: w_div_num = w_recv_num;
            ACT_DIV_SEND: w_div_num = w_send_num;
            ACT_DIV_DR: begin
                w_div_num = DIV_W'(r_d);
                w_div_den = DEN_W'(w_rwalk);
            end
            default:      w_is_div = 1'b0;
        endcase
    end

    assign w_div_start = w_is_div && !r_div_wait;

    kbs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot),
        .o_rem   (w_div_rem)
    );

    // ---------------- handshakes ----------------
    logic w_in_accept;
    logic w_out_accept;
    logic w_out_free;

    assign o_in_stall   = (w_uw.act != ACT_ACCEPT);
    assign w_in_accept  = i_in_valid && !o_in_stall;
    assign w_out_accept = r_out_valid && !i_out_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;

    // ---------------- emit fields ----------------
    logic              w_is_emit;
    logic [1:0]        w_em_kind;
    logic [RANK_W-1:0] w_em_peer;
    logic [ADDR_W-1:0] w_em_src;
    logic              w_em_last;

    always_comb begin
        w_is_emit = 1'b1;
        w_em_kind = KIND_DONE;
        w_em_peer = '0;
        w_em_src  = '0;
        w_em_last = 1'b1;
        unique case (w_uw.act)
            ACT_EMIT_COPY: begin
                w_em_kind = KIND_COPY;
                w_em_peer = r_me;
                w_em_src  = r_src;
                w_em_last = 1'b0;   // a walk or completion always follows
            end
            ACT_EMIT_RECV: begin
                w_em_kind = KIND_RECV;
                w_em_peer = r_peer;
            end
            ACT_EMIT_SEND: begin
                // valid children are contiguous from index 1, so index 1 ends the level
                w_em_kind = KIND_SEND;
                w_em_peer = r_peer;
                w_em_last = (r_i == POS_W'(1));
            end
            ACT_EMIT_DONE: w_em_kind = KIND_DONE;
            default:       w_is_emit = 1'b0;
        endcase
    end

    // ---------------- step completion and branch ----------------
    logic w_step_done;
    logic w_cond;
    logic w_emit;

    always_comb begin
        if (w_is_div)       w_step_done = r_div_wait && w_div_done;
        else if (w_is_emit) w_step_done = w_out_free;
        else                w_step_done = 1'b1;

        unique case (w_uw.br)
            BR_NEXT:    w_cond = 1'b0;
            BR_ALWAYS:  w_cond = 1'b1;
            BR_NOCOPY:  w_cond = !w_copy;
            BR_GS_ONE:  w_cond = (w_gs == GS_W'(1));
            BR_GROW:    w_cond = w_grow;
            BR_D_ZERO:  w_cond = (r_d == '0);
            BR_REM_NZ:  w_cond = r_rem_nz;
            BR_POS_Z:   w_cond = (r_pos == '0);
            BR_I_ZERO:  w_cond = (r_i == '0);
            BR_VP_GE:   w_cond = w_vp_ge;
            BR_POSTED:  w_cond = r_posted;
            BR_D_NZ:    w_cond = (r_d != '0);
            default:    w_cond = 1'b0;
        endcase
    end

    assign w_emit = w_is_emit && w_step_done;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= S_IDLE;
            r_phase     <= 1'b0;
            r_div_wait  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output slot refills in the cycle it drains; divide wait ends on done
            r_out_valid <= w_emit || (r_out_valid && !w_out_accept);
            r_div_wait  <= w_div_start || (r_div_wait && !w_div_done);

            if (w_emit) begin
                r_out_kind  <= w_em_kind;
                r_out_peer  <= w_em_peer;
                r_out_buf   <= r_buf;
                r_out_src   <= w_em_src;
                r_out_len   <= r_len;
                r_out_tag   <= r_tag;
                r_out_last  <= w_em_last;
            end

            if (w_uw.act == ACT_ACCEPT) begin
                if (w_in_accept) begin
                    if (i_cmd == CMD_START) begin
                        // a start abandons any parked broadcast
                        r_buf   <= i_buffer_addr;
                        r_src   <= i_source_addr;
                        r_len   <= i_byte_length;
                        r_tag   <= i_msg_tag;
                        r_radix <= w_radix_start;
                        r_pc    <= r_pc + PC_W'(1);
                    end else if (r_phase) begin
                        r_pc <= S_WALK;
                    end
                    // completion with nothing parked is dropped
                end
            end else if (w_step_done) begin
                r_pc <= w_cond ? w_uw.tgt : r_pc + PC_W'(1);
                unique case (w_uw.act)
                    ACT_DIV_ME:     r_me    <= w_div_rem[RANK_W-1:0];
                    ACT_DIV_ROOT:   r_root  <= w_div_rem[RANK_W-1:0];
                    ACT_VRANK:      r_vrank <= w_vmod[RANK_W-1:0];
                    ACT_D_INIT:     r_d     <= (w_gs == GS_W'(1)) ? '0 : GS_W'(1);
                    ACT_D_GROW: begin
                        if (w_grow) r_d <= w_grow_prod[GS_W-1:0];
                    end
                    ACT_CLR_POSTED: r_posted <= 1'b0;
                    ACT_DIV_VD: begin
                        r_q      <= w_div_quot[RANK_W-1:0];
                        r_rem_nz <= (w_div_rem != '0);
                    end
                    ACT_DIV_QR:     r_pos   <= w_div_rem[POS_W-1:0];
                    ACT_DIV_RECV:   r_peer  <= w_div_rem[RANK_W-1:0];
                    ACT_DIV_SEND:   r_peer  <= w_div_rem[RANK_W-1:0];
                    ACT_EMIT_RECV:  r_posted <= 1'b1;
                    ACT_EMIT_SEND:  r_posted <= 1'b1;
                    ACT_I_INIT:     r_i     <= POS_W'(w_rwalk - RADIX_W'(1));
                    ACT_I_DEC:      r_i     <= r_i - POS_W'(1);
                    ACT_DIV_DR:     r_d     <= w_div_quot[GS_W-1:0];
                    ACT_EMIT_DONE:  r_phase <= 1'b0;
                    ACT_PARK:       r_phase <= 1'b1;
                    default:        ;
                endcase
            end
        end
    end

    // ---------------- outputs ----------------
    assign o_out_valid  = r_out_valid;
    assign o_op_kind    = r_out_kind;
    assign o_peer_rank  = r_out_peer;
    assign o_out_buffer = r_out_buf;
    assign o_out_source = r_out_src;
    assign o_out_length = r_out_len;
    assign o_out_tag    = r_out_tag;
    assign o_last       = r_out_last;

endmodule
